// ----- design/slcd_pkg.sv -----
package slcd_pkg;

    // frame format
    localparam int unsigned MAX_LEN = 32;
    localparam int unsigned LEN_W   = $clog2(MAX_LEN + 1);
    localparam int unsigned IDX_W   = $clog2(MAX_LEN);

    localparam logic [7:0]  SYNC_FIRST  = 8'hA5;
    localparam logic [7:0]  SYNC_SECOND = 8'h5A;
    localparam logic [15:0] SEED_RESET  = 16'hBEAF;

    // receiver phases, plus the two replay states
    typedef enum logic [3:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_SUM_LO,
        PH_SUM_HI,
        PH_DATA,
        PH_EMIT_RD,
        PH_EMIT_WR
    } phase_t;

    // result kinds carried on tuser
    typedef enum logic [1:0] {
        ST_PAYLOAD = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_ERROR   = 2'd2
    } status_t;

endpackage

// ----- design/sync_length_checksum_deframer.sv -----
// a status-only result is presented in the cycle after the closing byte is accepted;
// a verified frame passes PH_EMIT_RD and PH_EMIT_WR, then its bytes follow one per cycle
// unless the output stalls. throughput: 1 input byte per cycle while receiving and output
// is free; input is held off while the payload buffer (registered read) replays n bytes.
// reset: async active low; hunts for the first sync byte, seed 0xBEAF, output empty.
module sync_length_checksum_deframer
    import slcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // config register
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,     // checksum_seed
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // rx_byte
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,       // payload_byte
    output logic [1:0]  m_tuser,       // frame_status
    output logic        m_tlast        // last_of_frame
);

    phase_t           phase_reg, phase_next;
    logic [15:0]      seed_reg;
    logic [7:0]       len_lo_reg, len_lo_next;
    logic [LEN_W-1:0] frame_len_reg, frame_len_next;
    logic [15:0]      exp_sum_reg, exp_sum_next;
    logic [15:0]      run_sum_reg, run_sum_next;
    logic [LEN_W-1:0] byte_count_reg, byte_count_next;
    logic [IDX_W-1:0] emit_idx_reg, emit_idx_next;

    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_data_reg, out_data_next;
    status_t          out_status_reg, out_status_next;
    logic             out_last_reg, out_last_next;

    // payload buffer
    logic [7:0]       mem [MAX_LEN];
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;
    logic [7:0]       mem_q;

    logic             out_free;
    logic             in_beat;
    logic [15:0]      sum_with_byte;
    logic [LEN_W:0]   count_plus;
    logic [LEN_W-1:0] count_inc;
    logic [LEN_W-1:0] emit_count;

    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = out_free && (phase_reg != PH_EMIT_RD) && (phase_reg != PH_EMIT_WR);
    assign in_beat   = s_tvalid && s_tready;

    assign sum_with_byte = run_sum_reg + {8'd0, s_tdata};
    assign count_inc     = byte_count_reg + LEN_W'(1);
    assign count_plus    = {1'b0, byte_count_reg} + (LEN_W + 1)'(3);
    assign emit_count    = {1'b0, emit_idx_reg} + LEN_W'(1);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= SEED_RESET;
        end
        else if (cfg_we)
        begin
            seed_reg <= cfg_wdata;
        end
    end

    // payload buffer write and registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= s_tdata;
        end
        if (mem_re)
        begin
            mem_q <= mem[mem_raddr];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SYNC1;
            frame_len_reg  <= '0;
            exp_sum_reg    <= '0;
            run_sum_reg    <= SEED_RESET;
            byte_count_reg <= '0;
            emit_idx_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            frame_len_reg  <= frame_len_next;
            exp_sum_reg    <= exp_sum_next;
            run_sum_reg    <= run_sum_next;
            byte_count_reg <= byte_count_next;
            emit_idx_reg   <= emit_idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        len_lo_reg     <= len_lo_next;
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    // next state and outputs
    always_comb
    begin
        phase_next      = phase_reg;
        len_lo_next     = len_lo_reg;
        frame_len_next  = frame_len_reg;
        exp_sum_next    = exp_sum_reg;
        run_sum_next    = run_sum_reg;
        byte_count_next = byte_count_reg;
        emit_idx_next   = emit_idx_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        mem_we          = 1'b0;
        mem_waddr       = byte_count_reg[IDX_W-1:0];
        mem_re          = 1'b0;
        mem_raddr       = '0;

        case (phase_reg)
            PH_SYNC1:
            begin
                if (in_beat && s_tdata == SYNC_FIRST)
                begin
                    phase_next = PH_SYNC2;
                end
            end
            PH_SYNC2:
            begin
                if (in_beat)
                begin
                    phase_next = (s_tdata == SYNC_SECOND) ? PH_LEN_LO : PH_SYNC1;
                end
            end
            PH_LEN_LO:
            begin
                if (in_beat)
                begin
                    len_lo_next = s_tdata;
                    phase_next  = PH_LEN_HI;
                end
            end
            PH_LEN_HI:
            begin
                if (in_beat)
                begin
                    // length must be 2..MAX_LEN, else back to the hunt
                    if (s_tdata == 8'd0 && len_lo_reg >= 8'd2 && len_lo_reg <= 8'(MAX_LEN))
                    begin
                        frame_len_next  = len_lo_reg[LEN_W-1:0];
                        run_sum_next    = seed_reg;
                        byte_count_next = '0;
                        phase_next      = PH_SUM_LO;
                    end
                    else
                    begin
                        phase_next = PH_SYNC1;
                    end
                end
            end
            PH_SUM_LO:
            begin
                if (in_beat)
                begin
                    exp_sum_next = {8'd0, s_tdata};
                    phase_next   = PH_SUM_HI;
                end
            end
            PH_SUM_HI:
            begin
                if (in_beat)
                begin
                    exp_sum_next = {s_tdata, exp_sum_reg[7:0]};
                    if (frame_len_reg <= LEN_W'(2))
                    begin
                        // frame without payload: status result right away
                        out_valid_next  = 1'b1;
                        out_data_next   = 8'd0;
                        out_last_next   = 1'b1;
                        out_status_next = (run_sum_reg == {s_tdata, exp_sum_reg[7:0]})
                                          ? ST_EMPTY : ST_ERROR;
                        phase_next      = PH_SYNC1;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
            end
            PH_DATA:
            begin
                if (in_beat)
                begin
                    // buffer the byte and fold it into the sum
                    mem_we          = 1'b1;
                    run_sum_next    = sum_with_byte;
                    byte_count_next = count_inc;
                    if (count_plus >= {1'b0, frame_len_reg})
                    begin
                        if (sum_with_byte != exp_sum_reg)
                        begin
                            out_valid_next  = 1'b1;
                            out_data_next   = 8'd0;
                            out_status_next = ST_ERROR;
                            out_last_next   = 1'b1;
                            phase_next      = PH_SYNC1;
                        end
                        else
                        begin
                            phase_next = PH_EMIT_RD;
                        end
                    end
                end
            end
            PH_EMIT_RD:
            begin
                // fetch the first buffered byte
                mem_re        = 1'b1;
                mem_raddr     = '0;
                emit_idx_next = '0;
                phase_next    = PH_EMIT_WR;
            end
            PH_EMIT_WR:
            begin
                // move fetched byte to the output and fetch the next one
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_data_next   = mem_q;
                    out_status_next = ST_PAYLOAD;
                    out_last_next   = (emit_count == byte_count_reg);
                    if (emit_count == byte_count_reg)
                    begin
                        phase_next = PH_SYNC1;
                    end
                    else
                    begin
                        mem_re        = 1'b1;
                        mem_raddr     = emit_idx_reg + IDX_W'(1);
                        emit_idx_next = emit_idx_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                phase_next = PH_SYNC1;
            end
        endcase
    end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps

import slcd_pkg::*;

typedef logic [7:0] byte_q_t [$];

// one expected output beat
typedef struct {
    logic [7:0] data;
    status_t    status;
    logic       last;
} frame_beat_t;

// tracks the receive state of the deframer and the beats it still owes
class frame_scoreboard;
    logic [15:0]   seed = SEED_RESET;
    phase_t        rx_phase = PH_SYNC1;
    logic [15:0]   frame_len = 16'h0000;
    logic [15:0]   sum_wanted = 16'h0000;
    logic [15:0]   sum_run = SEED_RESET;
    logic [5:0]    rx_count = 6'd0;
    logic [7:0]    payload_buf [MAX_LEN];
    frame_beat_t   pending [$];
    int            mismatches = 0;
    int            beats_checked = 0;
    int            frames_good = 0;
    int            frames_empty = 0;
    int            frames_bad = 0;

    function void set_seed(input logic [15:0] value);
        seed = value;
    endfunction

    // end of frame: queue the replay, the empty status or the error status
    function void close_frame();
        frame_beat_t b;
        rx_phase = PH_SYNC1;
        if (sum_run != sum_wanted)
        begin
            b = '{8'h00, ST_ERROR, 1'b1};
            pending.push_back(b);
            frames_bad++;
        end
        else if (rx_count == 0)
        begin
            b = '{8'h00, ST_EMPTY, 1'b1};
            pending.push_back(b);
            frames_empty++;
        end
        else
        begin
            for (int i = 0; i < rx_count; i++)
            begin
                b = '{payload_buf[i], ST_PAYLOAD, (i + 1 == rx_count)};
                pending.push_back(b);
            end
            frames_good++;
        end
    endfunction

    // accepted input beat
    function void note_rx_byte(input logic [7:0] rx);
        case (rx_phase)
            PH_SYNC1:
                if (rx == SYNC_FIRST)
                    rx_phase = PH_SYNC2;
            PH_SYNC2:
                rx_phase = (rx == SYNC_SECOND) ? PH_LEN_LO : PH_SYNC1;
            PH_LEN_LO:
            begin
                frame_len = {8'h00, rx};
                rx_phase  = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                frame_len[15:8] = rx;
                if (frame_len < 2 || frame_len > MAX_LEN)
                    rx_phase = PH_SYNC1;
                else
                begin
                    sum_run  = seed;
                    rx_count = 6'd0;
                    rx_phase = PH_SUM_LO;
                end
            end
            PH_SUM_LO:
            begin
                sum_wanted = {8'h00, rx};
                rx_phase   = PH_SUM_HI;
            end
            PH_SUM_HI:
            begin
                sum_wanted[15:8] = rx;
                if (frame_len <= 2)
                    close_frame();
                else
                    rx_phase = PH_DATA;
            end
            PH_DATA:
            begin
                if (rx_count < MAX_LEN)
                    payload_buf[rx_count] = rx;
                rx_count = rx_count + 6'd1;
                sum_run  = sum_run + {8'h00, rx};
                if (rx_count + 2 >= frame_len)
                    close_frame();
            end
            default:
                rx_phase = PH_SYNC1;
        endcase
    endfunction

    // accepted output beat against the oldest expectation
    function void check_beat(input logic [7:0] data, input logic [1:0] user,
                             input logic last);
        frame_beat_t want;
        beats_checked++;
        if (pending.size() == 0)
        begin
            mismatches++;
            $display("%0t: unexpected beat data %02h status %0d last %0b",
                     $time, data, user, last);
            return;
        end
        want = pending.pop_front();
        if (data !== want.data)
        begin
            mismatches++;
            $display("%0t: payload_byte expected %02h actual %02h",
                     $time, want.data, data);
        end
        if (user !== want.status)
        begin
            mismatches++;
            $display("%0t: frame_status expected %0d actual %0d",
                     $time, want.status, user);
        end
        if (last !== want.last)
        begin
            mismatches++;
            $display("%0t: last_of_frame expected %0b actual %0b",
                     $time, want.last, last);
        end
    endfunction
endclass

module tb;

    localparam int IDLE_LIMIT = 2000;
    localparam int LONG_HOLD  = 300;
    localparam int DRAIN_WAIT = 20;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = 16'h0000;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;      // rx_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;              // payload_byte
    logic [1:0]  m_tuser;              // frame_status
    logic        m_tlast;              // last_of_frame

    frame_scoreboard sb = new;

    logic [7:0]  tx_q [$];
    logic [15:0] seed_now = SEED_RESET;
    int          queued_total = 0;
    int          rx_beats = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    bit          sender_gaps = 1'b1;
    bit          receiver_stalls = 1'b1;
    int          hold_requests = 0;
    int          holds_taken = 0;
    int          hold_left = 0;
    int          rx_tick = 0;
    logic [15:0] stall_mask = 16'h0000;

    sync_length_checksum_deframer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #10 clk = ~clk;

    // input side: bursts of beats with random gaps in between
    always @(posedge clk or negedge rst_n)
    begin : byte_sender
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                void'(tx_q.pop_front());
                if (burst_left != 0)
                    burst_left--;
            end
            if (!s_tvalid || s_tready)
            begin
                if (burst_left == 0 && gap_left == 0 && tx_q.size() != 0)
                begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = sender_gaps ? $urandom_range(0, 6) : 0;
                end
                if (gap_left != 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (tx_q.size() != 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= tx_q[0];
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // output side: rotating stall mask, plus a long hold on request
    always @(posedge clk or negedge rst_n)
    begin : result_receiver
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (holds_taken != hold_requests)
            begin
                holds_taken = hold_requests;
                hold_left   = LONG_HOLD;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                rx_tick++;
                if (rx_tick % 64 == 0)
                    stall_mask = ($urandom_range(0, 3) == 0) ? 16'h0000
                                 : 16'($urandom) & 16'($urandom);
                m_tready <= !(receiver_stalls && stall_mask[rx_tick % 16]);
            end
        end
    end

    // handshake monitor and watchdog
    always @(posedge clk)
    begin : beat_monitor
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_beat(m_tdata, m_tuser, m_tlast);
            if (s_tvalid && s_tready)
            begin
                sb.note_rx_byte(s_tdata);
                rx_beats++;
            end
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    function automatic byte_q_t random_payload(input int n);
        byte_q_t q;
        for (int i = 0; i < n; i++)
            q.push_back(8'($urandom_range(0, 255)));
        return q;
    endfunction

    task automatic push_byte(input logic [7:0] b);
        tx_q.push_back(b);
        queued_total++;
    endtask

    // sync pair and little-endian length
    task automatic queue_header(input logic [15:0] len);
        push_byte(SYNC_FIRST);
        push_byte(SYNC_SECOND);
        push_byte(len[7:0]);
        push_byte(len[15:8]);
    endtask

    // complete frame; checksum from the current seed, one bit flipped if corrupt
    task automatic queue_frame(input byte_q_t payload, input bit corrupt);
        logic [15:0] sum;
        sum = seed_now;
        foreach (payload[i])
            sum = sum + {8'h00, payload[i]};
        if (corrupt)
            sum = sum ^ (16'h0001 << $urandom_range(0, 15));
        queue_header(16'(payload.size() + 2));
        push_byte(sum[7:0]);
        push_byte(sum[15:8]);
        foreach (payload[i])
            push_byte(payload[i]);
    endtask

    // mostly well-formed frames, the rest noise and broken sequences
    task automatic random_traffic(input int n_bytes);
        int stop_at;
        int pick;
        int len;
        stop_at = queued_total + n_bytes;
        while (queued_total < stop_at)
        begin
            pick = $urandom_range(0, 99);
            len  = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 8)
                                                : $urandom_range(9, MAX_LEN - 2);
            if (pick < 60)
                queue_frame(random_payload(len), 1'b0);
            else if (pick < 75)
                queue_frame(random_payload(len), 1'b1);
            else if (pick < 83)
            begin
                repeat ($urandom_range(1, 4))
                    push_byte(8'($urandom_range(0, 255)));
            end
            else if (pick < 90)
            begin
                // broken sync
                push_byte(SYNC_FIRST);
                if ($urandom_range(0, 1) == 0)
                    push_byte(SYNC_FIRST);
                else
                    push_byte(8'($urandom_range(0, 16'h59)));
            end
            else if (pick < 96)
            begin
                // length outside the legal range
                case ($urandom_range(0, 3))
                    0: queue_header(16'd0);
                    1: queue_header(16'd1);
                    2: queue_header(16'($urandom_range(MAX_LEN + 1, 255)));
                    default: queue_header({8'($urandom_range(1, 255)),
                                           8'($urandom_range(0, 255))});
                endcase
            end
            else
            begin
                // frame cut short, later bytes fill it up
                len = $urandom_range(2, MAX_LEN);
                queue_header(16'(len));
                repeat ($urandom_range(0, len - 1))
                    push_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic wait_idle();
        while (tx_q.size() != 0 || s_tvalid || sb.pending.size() != 0)
            @(posedge clk);
    endtask

    // seed write, only with both streams quiet
    task automatic write_seed(input logic [15:0] value);
        wait_idle();
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_seed(value);
        seed_now = value;
    endtask

    initial
    begin : stimulus
        byte_q_t pl;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty ok, empty error, byte extremes, broken sync, bad lengths
        pl = {};
        queue_frame(pl, 1'b0);
        queue_frame(pl, 1'b1);
        pl = '{8'h00, 8'hFF};
        queue_frame(pl, 1'b0);
        push_byte(SYNC_FIRST);
        push_byte(SYNC_FIRST);
        push_byte(SYNC_SECOND);
        queue_frame(random_payload(1), 1'b0);
        queue_header(16'd1);
        queue_header(16'(MAX_LEN + 1));
        queue_frame(random_payload(2), 1'b0);
        wait_idle();

        // zero seed, random gaps and stalls
        write_seed(16'h0000);
        random_traffic(70);

        // all-ones seed at full rate on both sides
        write_seed(16'hFFFF);
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
        random_traffic(70);
        wait_idle();
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;

        // output held off while longest frames keep coming
        write_seed(16'($urandom));
        hold_requests++;
        repeat (4)
            queue_frame(random_payload(MAX_LEN - 2), 1'b0);
        random_traffic(30);

        write_seed(16'($urandom));
        random_traffic(50);

        wait_idle();
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("covered %0d input beats and %0d output beats over 5 seed settings",
                 rx_beats, sb.beats_checked);
        $display("frames: %0d replayed, %0d empty, %0d checksum errors",
                 sb.frames_good, sb.frames_empty, sb.frames_bad);
        if (sb.pending.size() != 0)
            $display("%0t: %0d expected beats never arrived", $time, sb.pending.size());
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
